@@ rtl/spst_pkg.sv @@
`timescale 1ns / 1ps
// spst_pkg: shared constants, codes and types for the sorted priority slot table
// depends on nothing; used by spst_merge and sorted_priority_slot_table in rtl/ and by the testbench

package spst_pkg;

    // table geometry
    localparam int SLOTS         = 64;
    localparam int PRIORITY_BITS = 8;
    localparam int IDX_W         = $clog2(SLOTS);
    localparam int CNT_W         = $clog2(SLOTS + 1);

    // fixed field widths at the ports
    localparam int OP_W     = 2;
    localparam int REQ_W    = 8;
    localparam int NUM_W    = 7;
    localparam int STATUS_W = 2;
    localparam int PLACED_W = 6;
    localparam int VALUE_W  = 8;
    localparam int COUNT_W  = 7;

    // operation codes
    localparam logic [OP_W-1:0] OP_ADMIT   = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ    = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FREE    = 2'd3;

    // output of the merge compare unit
    typedef struct packed {
        logic [PRIORITY_BITS-1:0] emit;
        logic [PRIORITY_BITS-1:0] carry;
    } merge_res_t;

endpackage

@@ rtl/spst_ram.sv @@
`timescale 1ns / 1ps
// spst_ram: generic single-write, single-read RAM with registered read data
// no dependencies

module spst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/spst_merge.sv @@
`timescale 1ns / 1ps
// spst_merge: compare unit that merges a carried priority into the ordered stream
// depends on spst_pkg

module spst_merge (
    input  logic [spst_pkg::PRIORITY_BITS-1:0] carry,
    input  logic                               carry_vld,
    input  logic [spst_pkg::PRIORITY_BITS-1:0] value,
    output spst_pkg::merge_res_t               res
);

    logic value_lt;

    // single magnitude compare shared by every step of the pass
    assign value_lt = (value < carry);

    // emit the smaller, keep the larger for the next step; no carry: value passes
    always_comb
    begin
        if (carry_vld && !value_lt)
        begin
            res.emit  = carry;
            res.carry = value;
        end
        else
        begin
            res.emit  = value;
            res.carry = carry;
        end
    end

endmodule

@@ rtl/sorted_priority_slot_table.sv @@
`timescale 1ns / 1ps
// sorted_priority_slot_table: admit with room is one read pass over all slots, a final
// write and the result load; read adds a wait state for the registered RAM data;
// release, full, invalid and unused opcodes go straight to the result load; in_ready
// returns the cycle after the result is loaded, so input waits out a whole admit pass
// reset clears the occupancy bitmap and count, so every slot reads free at once;
// the slot RAM itself is never cleared. depends on spst_pkg, spst_ram, spst_merge

module sorted_priority_slot_table (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [spst_pkg::OP_W-1:0]       opcode,
    input  logic [spst_pkg::REQ_W-1:0]      priority_req,
    input  logic [spst_pkg::NUM_W-1:0]      slot_number,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [spst_pkg::STATUS_W-1:0]   status,
    output logic [spst_pkg::PLACED_W-1:0]   placed_slot,
    output logic [spst_pkg::VALUE_W-1:0]    slot_value,
    output logic [spst_pkg::COUNT_W-1:0]    occupied_count,
    output logic [spst_pkg::COUNT_W-1:0]    free_count
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FINAL,
        S_RDWAIT,
        S_POST
    } state_t;

    state_t                               state_reg, state_next;
    logic [spst_pkg::CNT_W-1:0]           scan_reg, scan_next;
    logic [spst_pkg::CNT_W-1:0]           wr_reg, wr_next;
    logic [spst_pkg::PRIORITY_BITS-1:0]   carry_reg, carry_next;
    logic                                 carry_vld_reg, carry_vld_next;
    logic                                 rd_pend_reg, rd_pend_next;
    logic                                 rd_occ_reg, rd_occ_next;
    logic [spst_pkg::IDX_W-1:0]           free_idx_reg, free_idx_next;
    logic [spst_pkg::SLOTS-1:0]           occ_reg, occ_next;
    logic [spst_pkg::CNT_W-1:0]           cnt_reg, cnt_next;
    logic [spst_pkg::STATUS_W-1:0]        res_status_reg, res_status_next;
    logic [spst_pkg::IDX_W-1:0]           res_placed_reg, res_placed_next;
    logic [spst_pkg::PRIORITY_BITS-1:0]   res_value_reg, res_value_next;
    logic                                 out_valid_reg, out_valid_next;
    logic [spst_pkg::STATUS_W-1:0]        out_status_reg, out_status_next;
    logic [spst_pkg::PLACED_W-1:0]        out_placed_reg, out_placed_next;
    logic [spst_pkg::VALUE_W-1:0]         out_value_reg, out_value_next;
    logic [spst_pkg::COUNT_W-1:0]         out_occ_reg, out_occ_next;
    logic [spst_pkg::COUNT_W-1:0]         out_free_reg, out_free_next;

    logic                                 ram_we;
    logic [spst_pkg::IDX_W-1:0]           ram_waddr;
    logic [spst_pkg::PRIORITY_BITS-1:0]   ram_wdata;
    logic                                 ram_re;
    logic [spst_pkg::IDX_W-1:0]           ram_raddr;
    logic [spst_pkg::PRIORITY_BITS-1:0]   ram_rdata;
    spst_pkg::merge_res_t                 merge_res;

    logic [spst_pkg::PRIORITY_BITS-1:0]   req_prio;
    logic [spst_pkg::IDX_W-1:0]           req_idx;
    logic                                 num_ok;
    logic [spst_pkg::IDX_W-1:0]           scan_idx;
    logic [spst_pkg::CNT_W-1:0]           fill_cnt;
    logic [spst_pkg::SLOTS-1:0]           fill_mask;

    // slot storage
    spst_ram #(
        .WIDTH (spst_pkg::PRIORITY_BITS),
        .DEPTH (spst_pkg::SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared compare unit for the ordered rewrite
    spst_merge u_merge (
        .carry     (carry_reg),
        .carry_vld (carry_vld_reg),
        .value     (ram_rdata),
        .res       (merge_res)
    );

    // request decode
    assign req_prio = spst_pkg::PRIORITY_BITS'(priority_req);
    assign req_idx  = spst_pkg::IDX_W'(slot_number - spst_pkg::NUM_W'(1));
    assign num_ok   = (slot_number != '0) && (32'(slot_number) <= spst_pkg::SLOTS);
    assign scan_idx = scan_reg[spst_pkg::IDX_W-1:0];

    // packed occupancy after the pass: the first fill_cnt slots hold entries
    assign fill_cnt = wr_reg + spst_pkg::CNT_W'(carry_vld_reg);

    always_comb
    begin
        for (int i = 0; i < spst_pkg::SLOTS; i++)
        begin
            fill_mask[i] = (spst_pkg::CNT_W'(i) < fill_cnt);
        end
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        scan_next       = scan_reg;
        wr_next         = wr_reg;
        carry_next      = carry_reg;
        carry_vld_next  = carry_vld_reg;
        rd_pend_next    = rd_pend_reg;
        rd_occ_next     = rd_occ_reg;
        free_idx_next   = free_idx_reg;
        occ_next        = occ_reg;
        cnt_next        = cnt_reg;
        res_status_next = res_status_reg;
        res_placed_next = res_placed_reg;
        res_value_next  = res_value_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_placed_next = out_placed_reg;
        out_value_next  = out_value_reg;
        out_occ_next    = out_occ_reg;
        out_free_next   = out_free_reg;

        ram_we    = 1'b0;
        ram_waddr = wr_reg[spst_pkg::IDX_W-1:0];
        ram_wdata = merge_res.emit;
        ram_re    = 1'b0;
        ram_raddr = scan_idx;

        // result taken downstream
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                ram_raddr = req_idx;
                if (in_valid)
                begin
                    res_status_next = spst_pkg::ST_OK;
                    res_placed_next = '0;
                    res_value_next  = '0;
                    state_next      = S_POST;
                    case (opcode)
                        spst_pkg::OP_ADMIT:
                        begin
                            if (cnt_reg == spst_pkg::CNT_W'(spst_pkg::SLOTS))
                            begin
                                res_status_next = spst_pkg::ST_FULL;
                            end
                            else
                            begin
                                scan_next      = '0;
                                wr_next        = '0;
                                carry_next     = req_prio;
                                carry_vld_next = (req_prio != '0);
                                rd_pend_next   = 1'b0;
                                free_idx_next  = '0;
                                state_next     = S_SCAN;
                            end
                        end
                        spst_pkg::OP_RELEASE:
                        begin
                            if (!num_ok)
                            begin
                                res_status_next = spst_pkg::ST_INVALID;
                            end
                            else if (occ_reg[req_idx])
                            begin
                                occ_next[req_idx] = 1'b0;
                                cnt_next          = cnt_reg - spst_pkg::CNT_W'(1);
                            end
                            else
                            begin
                                res_status_next = spst_pkg::ST_FREE;
                            end
                        end
                        spst_pkg::OP_READ:
                        begin
                            if (!num_ok)
                            begin
                                res_status_next = spst_pkg::ST_INVALID;
                            end
                            else
                            begin
                                ram_re      = 1'b1;
                                rd_occ_next = occ_reg[req_idx];
                                state_next  = S_RDWAIT;
                            end
                        end
                        default:
                        begin
                            res_status_next = spst_pkg::ST_OK;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // issue side: one slot read per cycle, track the highest free slot
                if (scan_reg != spst_pkg::CNT_W'(spst_pkg::SLOTS))
                begin
                    ram_re       = 1'b1;
                    rd_pend_next = 1'b1;
                    rd_occ_next  = occ_reg[scan_idx];
                    if (!occ_reg[scan_idx])
                    begin
                        free_idx_next = scan_idx;
                    end
                    scan_next = scan_reg + spst_pkg::CNT_W'(1);
                end
                else
                begin
                    rd_pend_next = 1'b0;
                    state_next   = S_FINAL;
                end
                // return side: compact occupied entries, merging the new priority
                if (rd_pend_reg && rd_occ_reg)
                begin
                    ram_we     = 1'b1;
                    carry_next = merge_res.carry;
                    wr_next    = wr_reg + spst_pkg::CNT_W'(1);
                end
            end

            S_FINAL:
            begin
                // flush the carried entry and rebuild occupancy
                if (carry_vld_reg)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = carry_reg;
                end
                occ_next        = fill_mask;
                cnt_next        = fill_cnt;
                res_status_next = spst_pkg::ST_OK;
                res_placed_next = free_idx_reg;
                state_next      = S_POST;
            end

            S_RDWAIT:
            begin
                res_value_next = rd_occ_reg ? ram_rdata : '0;
                state_next     = S_POST;
            end

            S_POST:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_placed_next = spst_pkg::PLACED_W'(res_placed_reg);
                    out_value_next  = spst_pkg::VALUE_W'(res_value_reg);
                    out_occ_next    = spst_pkg::COUNT_W'(cnt_reg);
                    out_free_next   = spst_pkg::COUNT_W'(
                                          spst_pkg::CNT_W'(spst_pkg::SLOTS) - cnt_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            scan_reg       <= '0;
            wr_reg         <= '0;
            carry_reg      <= '0;
            carry_vld_reg  <= 1'b0;
            rd_pend_reg    <= 1'b0;
            rd_occ_reg     <= 1'b0;
            free_idx_reg   <= '0;
            occ_reg        <= '0;
            cnt_reg        <= '0;
            res_status_reg <= '0;
            res_placed_reg <= '0;
            res_value_reg  <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= '0;
            out_placed_reg <= '0;
            out_value_reg  <= '0;
            out_occ_reg    <= '0;
            out_free_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_reg       <= scan_next;
            wr_reg         <= wr_next;
            carry_reg      <= carry_next;
            carry_vld_reg  <= carry_vld_next;
            rd_pend_reg    <= rd_pend_next;
            rd_occ_reg     <= rd_occ_next;
            free_idx_reg   <= free_idx_next;
            occ_reg        <= occ_next;
            cnt_reg        <= cnt_next;
            res_status_reg <= res_status_next;
            res_placed_reg <= res_placed_next;
            res_value_reg  <= res_value_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_placed_reg <= out_placed_next;
            out_value_reg  <= out_value_next;
            out_occ_reg    <= out_occ_next;
            out_free_reg   <= out_free_next;
        end
    end

    // port drive
    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign placed_slot    = out_placed_reg;
    assign slot_value     = out_value_reg;
    assign occupied_count = out_occ_reg;
    assign free_count     = out_free_reg;

    // occupied count tracks the occupancy bitmap
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(occ_reg) == 32'(cnt_reg))
        else $error("occupied count out of step with occupancy bitmap");

    // compaction write never lands on the slot being read
    assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("slot ram write collides with read");

    // write pointer stays behind the read pointer during the pass
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (wr_reg <= scan_reg))
        else $error("compaction write pointer overtook read pointer");

    // a result is only presented out of the result load state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_POST))
        else $error("result presented outside result load");

endmodule

@@ tb/sorted_priority_slot_table_test.sv @@
`timescale 1ns / 1ps
// sorted_priority_slot_table_test: self-checking testbench for the sorted priority slot table
// depends on spst_pkg and sorted_priority_slot_table; holds its own model of the slot table

module sorted_priority_slot_table_test;

    // opcode with no operation behind it, only counts come back
    localparam logic [spst_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [spst_pkg::STATUS_W-1:0] status;
        logic [spst_pkg::PLACED_W-1:0] placed;
        logic [spst_pkg::VALUE_W-1:0]  value;
        logic [spst_pkg::COUNT_W-1:0]  occupied;
        logic [spst_pkg::COUNT_W-1:0]  free;
    } slot_result_t;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic [spst_pkg::OP_W-1:0]     opcode;
    logic [spst_pkg::REQ_W-1:0]    priority_req;
    logic [spst_pkg::NUM_W-1:0]    slot_number;
    logic                          out_valid;
    logic                          out_ready;
    logic [spst_pkg::STATUS_W-1:0] status;
    logic [spst_pkg::PLACED_W-1:0] placed_slot;
    logic [spst_pkg::VALUE_W-1:0]  slot_value;
    logic [spst_pkg::COUNT_W-1:0]  occupied_count;
    logic [spst_pkg::COUNT_W-1:0]  free_count;

    // model of the table and the results still owed by the block
    logic [spst_pkg::PRIORITY_BITS-1:0] slot_model [spst_pkg::SLOTS];
    slot_result_t                       expected_results [$];

    int error_count    = 0;
    int result_count   = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int stall_request  = 0;

    sorted_priority_slot_table u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .priority_req   (priority_req),
        .slot_number    (slot_number),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .placed_slot    (placed_slot),
        .slot_value     (slot_value),
        .occupied_count (occupied_count),
        .free_count     (free_count)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    initial
    begin
        #4_800_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // table empty after reset
    initial
    begin
        for (int i = 0; i < spst_pkg::SLOTS; i++)
        begin
            slot_model[i] = '0;
        end
    end

    function automatic int occupied_slots();
        int n;
        n = 0;
        for (int i = 0; i < spst_pkg::SLOTS; i++)
        begin
            if (slot_model[i] != 0)
            begin
                n++;
            end
        end
        return n;
    endfunction

    // apply one operation to the model table and return the result it gives
    function automatic slot_result_t apply_slot_op(input logic [spst_pkg::OP_W-1:0] op,
                                                   input logic [spst_pkg::REQ_W-1:0] prio,
                                                   input logic [spst_pkg::NUM_W-1:0] num);
        slot_result_t                       r;
        logic [spst_pkg::PRIORITY_BITS-1:0] sorted_vals [spst_pkg::SLOTS];
        logic [spst_pkg::PRIORITY_BITS-1:0] v;
        int                                 i;
        int                                 n;
        int                                 k;
        int                                 hole;
        int                                 occ;
        r    = '0;
        hole = -1;
        case (op)
            spst_pkg::OP_ADMIT:
            begin
                // highest-numbered free slot takes the new priority
                for (i = spst_pkg::SLOTS - 1; i >= 0 && hole < 0; i--)
                begin
                    if (slot_model[i] == 0)
                    begin
                        hole = i;
                    end
                end
                if (hole < 0)
                begin
                    r.status = spst_pkg::ST_FULL;
                end
                else
                begin
                    slot_model[hole] = prio[spst_pkg::PRIORITY_BITS-1:0];
                    r.placed         = hole[spst_pkg::PLACED_W-1:0];
                    // pack occupied entries to the front in ascending order
                    n = 0;
                    for (i = 0; i < spst_pkg::SLOTS; i++)
                    begin
                        v = slot_model[i];
                        if (v != 0)
                        begin
                            k = n;
                            while (k > 0 && sorted_vals[k-1] > v)
                            begin
                                sorted_vals[k] = sorted_vals[k-1];
                                k--;
                            end
                            sorted_vals[k] = v;
                            n++;
                        end
                    end
                    for (i = 0; i < spst_pkg::SLOTS; i++)
                    begin
                        slot_model[i] = (i < n) ? sorted_vals[i] : '0;
                    end
                end
            end
            spst_pkg::OP_RELEASE, spst_pkg::OP_READ:
            begin
                if (num < 1 || num > spst_pkg::SLOTS)
                begin
                    r.status = spst_pkg::ST_INVALID;
                end
                else if (op == spst_pkg::OP_RELEASE)
                begin
                    if (slot_model[num-1] != 0)
                    begin
                        slot_model[num-1] = '0;
                    end
                    else
                    begin
                        r.status = spst_pkg::ST_FREE;
                    end
                end
                else
                begin
                    r.value = spst_pkg::VALUE_W'(slot_model[num-1]);
                end
            end
            default:
            begin
            end
        endcase
        occ        = occupied_slots();
        r.occupied = occ[spst_pkg::COUNT_W-1:0];
        r.free     = spst_pkg::COUNT_W'(spst_pkg::SLOTS - occ);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        if (error_count <= 40)
        begin
            $display("result %0d: %s got %0d, want %0d", result_count, what, got, want);
        end
    endtask

    // offer one item, wait for its transfer, then record what it should give
    task automatic send_slot_op(input logic [spst_pkg::OP_W-1:0] op,
                                input logic [spst_pkg::REQ_W-1:0] prio,
                                input logic [spst_pkg::NUM_W-1:0] num);
        int gap;
        if (send_idle_pct > 0)
        begin
            gap = 0;
            while ($urandom_range(0, 99) < send_idle_pct)
            begin
                gap++;
            end
            // now and then a long gap so idling lands anywhere in an admit pass
            if ($urandom_range(0, 49) == 0)
            begin
                gap = gap + $urandom_range(1, 80);
            end
            for (int c = 0; c < gap; c++)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        priority_req <= prio;
        slot_number  <= num;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        expected_results.push_back(apply_slot_op(op, prio, num));
    endtask

    // random item biased toward the occupied front of the table
    task automatic send_random_op(input int admit_pct);
        int                         roll;
        int                         occ;
        logic [spst_pkg::OP_W-1:0]  op;
        logic [spst_pkg::REQ_W-1:0] prio;
        logic [spst_pkg::NUM_W-1:0] num;
        occ  = occupied_slots();
        roll = $urandom_range(0, 99);
        if (roll < admit_pct)
        begin
            op = spst_pkg::OP_ADMIT;
        end
        else if (roll < admit_pct + (100 - admit_pct) / 2)
        begin
            op = spst_pkg::OP_RELEASE;
        end
        else if (roll < 97)
        begin
            op = spst_pkg::OP_READ;
        end
        else
        begin
            op = OP_UNUSED;
        end
        roll = $urandom_range(0, 99);
        if (roll < 4)
        begin
            prio = '0;
        end
        else if (roll < 8)
        begin
            prio = 8'd255;
        end
        else if (roll < 12)
        begin
            prio = 8'd1;
        end
        else
        begin
            prio = spst_pkg::REQ_W'($urandom_range(1, 255));
        end
        roll = $urandom_range(0, 99);
        if (roll < 8)
        begin
            num = '0;
        end
        else if (roll < 16)
        begin
            num = spst_pkg::NUM_W'($urandom_range(spst_pkg::SLOTS + 1, 127));
        end
        else if (roll < 70)
        begin
            num = spst_pkg::NUM_W'($urandom_range(1, (occ > 0) ? occ : 1));
        end
        else
        begin
            num = spst_pkg::NUM_W'($urandom_range(1, spst_pkg::SLOTS));
        end
        send_slot_op(op, prio, num);
    endtask

    // edge values, every opcode and the invalid and free statuses
    task automatic test_directed_cases();
        send_slot_op(spst_pkg::OP_ADMIT, 8'd255, 7'd0);
        send_slot_op(spst_pkg::OP_ADMIT, 8'd1, 7'd127);
        send_slot_op(spst_pkg::OP_ADMIT, 8'd0, 7'd5);
        send_slot_op(spst_pkg::OP_ADMIT, 8'd128, 7'd64);
        send_slot_op(spst_pkg::OP_READ, 8'd0, 7'd1);
        send_slot_op(spst_pkg::OP_READ, 8'd255, 7'd2);
        send_slot_op(spst_pkg::OP_READ, 8'd0, 7'd3);
        send_slot_op(spst_pkg::OP_READ, 8'd0, 7'd64);
        send_slot_op(spst_pkg::OP_READ, 8'd0, 7'd0);
        send_slot_op(spst_pkg::OP_READ, 8'd0, 7'd65);
        send_slot_op(spst_pkg::OP_READ, 8'd0, 7'd127);
        send_slot_op(spst_pkg::OP_RELEASE, 8'd0, 7'd0);
        send_slot_op(spst_pkg::OP_RELEASE, 8'd255, 7'd127);
        send_slot_op(spst_pkg::OP_RELEASE, 8'd0, 7'd65);
        send_slot_op(spst_pkg::OP_RELEASE, 8'd0, 7'd64);
        send_slot_op(spst_pkg::OP_RELEASE, 8'd0, 7'd2);
        send_slot_op(spst_pkg::OP_READ, 8'd0, 7'd2);
        send_slot_op(spst_pkg::OP_ADMIT, 8'd200, 7'd0);
        send_slot_op(OP_UNUSED, 8'd0, 7'd0);
        send_slot_op(OP_UNUSED, 8'd255, 7'd127);
        send_slot_op(spst_pkg::OP_RELEASE, 8'd0, 7'd1);
        send_slot_op(spst_pkg::OP_RELEASE, 8'd0, 7'd1);
        send_slot_op(spst_pkg::OP_READ, 8'd0, 7'd1);
    endtask

    // fill every slot, then hit the full case and refill a single hole
    task automatic test_fill_to_full();
        while (occupied_slots() < spst_pkg::SLOTS)
        begin
            send_slot_op(spst_pkg::OP_ADMIT, spst_pkg::REQ_W'($urandom_range(1, 255)),
                         spst_pkg::NUM_W'($urandom_range(0, 127)));
        end
        send_slot_op(spst_pkg::OP_ADMIT, 8'd77, 7'd0);
        send_slot_op(spst_pkg::OP_ADMIT, 8'd0, 7'd0);
        send_slot_op(spst_pkg::OP_READ, 8'd0, 7'd64);
        send_slot_op(spst_pkg::OP_RELEASE, 8'd0, 7'd33);
        send_slot_op(spst_pkg::OP_READ, 8'd0, 7'd33);
        send_slot_op(spst_pkg::OP_RELEASE, 8'd0, 7'd33);
        send_slot_op(spst_pkg::OP_ADMIT, 8'd9, 7'd0);
        send_slot_op(spst_pkg::OP_READ, 8'd0, 7'd1);
        send_slot_op(spst_pkg::OP_READ, 8'd0, 7'd64);
    endtask

    task automatic test_random_traffic(input int n_items, input int admit_pct);
        for (int i = 0; i < n_items; i++)
        begin
            send_random_op(admit_pct);
        end
    endtask

    // receiver holds off for a long stretch while items keep coming
    task automatic test_output_backpressure();
        stall_request = 400;
        for (int i = 0; i < 14; i++)
        begin
            send_random_op(60);
        end
    endtask

    // receiver ready, random stalls and the long hold-off
    initial
    begin
        int held;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_request > 0)
            begin
                held          = stall_request;
                stall_request = 0;
                out_ready <= 1'b0;
                while (held > 0)
                begin
                    @(posedge clk);
                    held--;
                end
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin : check_result
        slot_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            result_count++;
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result, status", status, 0);
            end
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.status)
                begin
                    report_mismatch("status", status, want.status);
                end
                if (placed_slot !== want.placed)
                begin
                    report_mismatch("placed_slot", placed_slot, want.placed);
                end
                if (slot_value !== want.value)
                begin
                    report_mismatch("slot_value", slot_value, want.value);
                end
                if (occupied_count !== want.occupied)
                begin
                    report_mismatch("occupied_count", occupied_count, want.occupied);
                end
                if (free_count !== want.free)
                begin
                    report_mismatch("free_count", free_count, want.free);
                end
            end
        end
    end

    // test sequence
    initial
    begin
        in_valid     <= 1'b0;
        opcode       <= spst_pkg::OP_ADMIT;
        priority_req <= '0;
        slot_number  <= '0;
        rst_n        <= 1'b0;
        send_idle_pct  = 9;
        recv_stall_pct = 60;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_fill_to_full();
        test_random_traffic(160, 70);

        send_idle_pct  = 60;
        recv_stall_pct = 9;
        test_random_traffic(160, 45);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_traffic(120, 60);
        test_output_backpressure();
        in_valid <= 1'b0;

        // drain, then give a stray result time to show up
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (spst_pkg::SLOTS + 16) @(posedge clk);
        if (error_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/spst_pkg.sv
rtl/spst_ram.sv
rtl/spst_merge.sv
rtl/sorted_priority_slot_table.sv
tb/sorted_priority_slot_table_test.sv
